// File: sv/sul_pkg.sv
`default_nettype none

package sul_pkg;

  localparam int CAPACITY    = 8;
  localparam int VALUE_WIDTH = 32;
  localparam int POS_W       = 3;
  localparam int CNT_W       = 4;
  localparam int STATUS_W    = 3;
  localparam int OPCODE_W    = 2;

  // Request opcodes.
  localparam logic [OPCODE_W-1:0] OP_ADD  = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_DEL  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_LIST = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DUP      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic add;         // insert value_i this cycle
    logic del;         // remove value_i this cycle
    logic list_empty;  // emit the single result of a list on an empty list
    logic list_begin;  // clear the readout index
    logic list_step;   // emit the entry at the readout index and advance
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;       // no entries held
    logic last_idx;    // readout index points at the final held entry
  } stat_t;

endpackage

`default_nettype wire

// File: sv/sul_ctrl.sv
`default_nettype none

module sul_ctrl
  import sul_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire logic [OPCODE_W-1:0] opcode_i,
  input  wire stat_t               stat_i,
  output logic                     busy_o,
  output cmd_t                     cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_LIST = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign busy_o = (state_q == S_LIST);
  assign accept = start_i && !busy_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (opcode_i)
            OP_ADD:  cmd_o.add = 1'b1;
            OP_DEL:  cmd_o.del = 1'b1;
            OP_LIST: begin
              if (stat_i.empty) begin
                cmd_o.list_empty = 1'b1;
              end else begin
                cmd_o.list_begin = 1'b1;
                state_d          = S_LIST;
              end
            end
            default: ;
          endcase
        end
      end
      S_LIST: begin
        cmd_o.list_step = 1'b1;
        if (stat_i.last_idx) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // A readout ends once the final entry has been stepped out.
  a_list_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o && stat_i.last_idx |=> !busy_o)
    else $error("list readout did not end after the final entry");

  // A readout never starts on an empty list.
  a_no_empty_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.list_begin |-> !stat_i.empty)
    else $error("list readout started on an empty list");

  // While a readout runs, the readout step is the only command issued.
  a_busy_steps_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> cmd_o.list_step && !cmd_o.add && !cmd_o.del
               && !cmd_o.list_empty && !cmd_o.list_begin)
    else $error("command other than a readout step issued during a readout");

endmodule

`default_nettype wire

// File: sv/sul_dpath.sv
`default_nettype none

module sul_dpath
  import sul_pkg::*;
(
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire cmd_t                          cmd_i,
  input  wire logic signed [VALUE_WIDTH-1:0] value_i,
  output stat_t                              stat_o,
  output logic                               done_o,
  output logic [STATUS_W-1:0]                status_o,
  output logic signed [VALUE_WIDTH-1:0]      entry_value_o,
  output logic [POS_W-1:0]                   position_o,
  output logic [CNT_W-1:0]                   entry_count_o,
  output logic                               last_o
);

  logic signed [VALUE_WIDTH-1:0] ent_q [CAPACITY];
  logic signed [VALUE_WIDTH-1:0] ent_d [CAPACITY];
  logic [CNT_W-1:0]              cnt_q, cnt_d;
  logic [POS_W-1:0]              idx_q, idx_d;

  logic [CAPACITY-1:0] lt, eq;
  logic [CNT_W-1:0]    ins_cnt;
  logic [POS_W-1:0]    del_pos;
  logic                full, dup, found;
  logic                add_ok, del_ok;

  logic                          done_d, last_d;
  logic [STATUS_W-1:0]           status_d;
  logic signed [VALUE_WIDTH-1:0] value_d;
  logic [POS_W-1:0]              pos_d;

  // Parallel compare of the request value against every held entry.
  always_comb begin
    ins_cnt = '0;
    del_pos = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      lt[i] = (CNT_W'(i) < cnt_q) && (ent_q[i] < value_i);
      eq[i] = (CNT_W'(i) < cnt_q) && (ent_q[i] == value_i);
      ins_cnt = ins_cnt + CNT_W'(lt[i]);
      if (eq[i]) begin
        del_pos = del_pos | POS_W'(i);
      end
    end
  end

  assign full   = (cnt_q == CNT_W'(CAPACITY));
  assign dup    = |eq;
  assign found  = |eq;
  assign add_ok = cmd_i.add && !full && !dup;
  assign del_ok = cmd_i.del && found;

  assign stat_o.empty    = (cnt_q == '0);
  assign stat_o.last_idx = ({1'b0, idx_q} == cnt_q - CNT_W'(1));

  // Entry shifting for insert and remove.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      ent_d[i] = ent_q[i];
    end
    if (add_ok) begin
      if (ins_cnt == '0) begin
        ent_d[0] = value_i;
      end
      for (int i = 1; i < CAPACITY; i++) begin
        if (CNT_W'(i) == ins_cnt) begin
          ent_d[i] = value_i;
        end else if (CNT_W'(i) > ins_cnt) begin
          ent_d[i] = ent_q[i-1];
        end
      end
    end else if (del_ok) begin
      for (int i = 0; i < CAPACITY - 1; i++) begin
        if (POS_W'(i) >= del_pos) begin
          ent_d[i] = ent_q[i+1];
        end
      end
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (add_ok) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (del_ok) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.list_begin) begin
      idx_d = '0;
    end else if (cmd_i.list_step) begin
      idx_d = idx_q + POS_W'(1);
    end
  end

  // Result selection.
  always_comb begin
    done_d   = 1'b0;
    status_d = ST_OK;
    value_d  = value_i;
    pos_d    = '0;
    last_d   = 1'b1;
    if (cmd_i.add) begin
      done_d = 1'b1;
      if (full) begin
        status_d = ST_FULL;
      end else if (dup) begin
        status_d = ST_DUP;
      end else begin
        pos_d = ins_cnt[POS_W-1:0];
      end
    end else if (cmd_i.del) begin
      done_d = 1'b1;
      if (stat_o.empty) begin
        status_d = ST_EMPTY;
      end else if (!found) begin
        status_d = ST_NOTFOUND;
      end else begin
        pos_d = del_pos;
      end
    end else if (cmd_i.list_empty) begin
      done_d   = 1'b1;
      status_d = ST_EMPTY;
      value_d  = '0;
    end else if (cmd_i.list_step) begin
      done_d  = 1'b1;
      value_d = ent_q[idx_q];
      pos_d   = idx_q;
      last_d  = stat_o.last_idx;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < CAPACITY; i++) begin
      ent_q[i] <= ent_d[i];
    end
    idx_q         <= idx_d;
    status_o      <= status_d;
    entry_value_o <= value_d;
    position_o    <= pos_d;
    entry_count_o <= cnt_d;
    last_o        <= last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_o <= done_d;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_add_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    add_ok |=> (cnt_q == $past(cnt_q) + CNT_W'(1)) && done_o && (status_o == ST_OK))
    else $error("accepted insert did not grow the list by one");

  a_step_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.list_step |=> done_o && (position_o == $past(idx_q)))
    else $error("list step did not emit the indexed entry");

endmodule

`default_nettype wire

// File: sv/sorted_unique_list.sv
`default_nettype none

// Channel   Direction  Ports                                         Handshake
// request   in         opcode_i, value_i                             start_i && !busy_o
// result    out        status_o, entry_value_o, position_o,          done_o, one cycle
//                      entry_count_o, last_o
//
// An add or delete request gives its single result in the cycle after it is taken, and
// busy_o stays low, so a new request may follow in every cycle.
// A list request on a held list of N entries raises busy_o once it is taken and steps out
// one entry per cycle from a counter that steps through the entry registers; each of the
// N results is registered from its step, and the next request can be taken at the edge
// that ends the final result.
// A list on an empty list gives one result like an add does.
// Reset (rst_ni low, asynchronous) empties the list; no clearing pass is needed.
// Results carry no back-pressure: each stands for exactly one cycle under done_o.

module sorted_unique_list
  import sul_pkg::*;
(
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire logic [OPCODE_W-1:0]           opcode_i,
  input  wire logic signed [VALUE_WIDTH-1:0] value_i,
  output logic                               done_o,
  output logic [STATUS_W-1:0]                status_o,
  output logic signed [VALUE_WIDTH-1:0]      entry_value_o,
  output logic [POS_W-1:0]                   position_o,
  output logic [CNT_W-1:0]                   entry_count_o,
  output logic                               last_o
);

  // The controller decodes each accepted request into one command and sequences the
  // list readout; the datapath holds the sorted entries, compares the request value
  // against all of them at once and registers every result.
  cmd_t  cmd;
  stat_t stat;

  sul_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .opcode_i (opcode_i),
    .stat_i   (stat),
    .busy_o   (busy_o),
    .cmd_o    (cmd)
  );

  sul_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .value_i       (value_i),
    .stat_o        (stat),
    .done_o        (done_o),
    .status_o      (status_o),
    .entry_value_o (entry_value_o),
    .position_o    (position_o),
    .entry_count_o (entry_count_o),
    .last_o        (last_o)
  );

endmodule

`default_nettype wire
